// ----- rtl/core/zsle_pkg.sv -----
`timescale 1ns / 1ps
// Shared package for the z-score to log10 E-value block.
// Holds config register indexes, pipeline flag type and the tail table.
package zsle_pkg;

  localparam int TABLE_ENTRIES_DEF = 80;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int KNOWN_POINTS      = 80;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 32;
  localparam int SCORE_W           = 32;
  localparam int STD_DEV_W         = 31;
  localparam int DB_SIZE_W         = 22;
  localparam int OUT_W             = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN    = 2'd0,
    CFG_STD_DEV = 2'd1,
    CFG_DB_SIZE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic below;
    logic clamp;
  } zsle_flags_t;

  // magnitudes of log10 upper-tail normal probabilities, millionths
  localparam longint TAIL_MICRO [KNOWN_POINTS] = '{
    301030, 337080, 375986, 417836, 462712, 510692, 561848, 616250,
    673960, 735040, 799546, 867529, 939039, 1014120, 1092820, 1175180,
    1261230, 1351000, 1444540, 1541870, 1643020, 1748010, 1856880, 1969640,
    2086320, 2206930, 2331500, 2460050, 2592590, 2729130, 2869700, 3014300,
    3162960, 3315670, 3472460, 3633340, 3798310, 3967380, 4140570, 4317890,
    4499330, 4684920, 4874660, 5068550, 5266600, 5468820, 5675210, 5885790,
    6100550, 6319500, 6542650, 6769990, 7001550, 7237310, 7477290, 7721490,
    7969900, 8222550, 8479420, 8740520, 9005860, 9275440, 9549260, 9827330,
    10109600, 10396200, 10687000, 10982100, 11281400, 11585000, 11892900, 12205000,
    12521400, 12842000, 13166800, 13496000, 13829100, 14165700, 14507400, 14857700
  };

  // table entry in frac_bits fraction bits, rounded half away from zero;
  // evaluated at elaboration only
  function automatic longint tail_val(int idx, int frac_bits);
    int     i;
    longint mag;
    i   = (idx < KNOWN_POINTS) ? idx : KNOWN_POINTS - 1;
    mag = (TAIL_MICRO[i] <<< frac_bits) + 64'sd500000;
    return -(mag / 64'sd1000000);
  endfunction

endpackage

// ----- rtl/core/zsle_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: score input, result output, config writes.
// Depends on zsle_pkg for field widths.
interface zsle_in_if import zsle_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score_value;
  modport source (output valid, output score_value, input ready);
  modport sink   (input valid, input score_value, output ready);
endinterface

interface zsle_out_if import zsle_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] log_evalue;
  logic                    below_mean;
  logic                    clamped;
  modport source (output valid, output log_evalue, output below_mean, output clamped,
                  input ready);
  modport sink   (input valid, input log_evalue, input below_mean, input clamped,
                  output ready);
endinterface

interface zsle_cfg_if import zsle_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/zsle_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division cell: yields one quotient bit per item.
// Depends on zsle_pkg.
module zsle_div_cell import zsle_pkg::*; #(
  parameter int QW = 23
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  zsle_flags_t          flags_i,
  input  logic [STD_DEV_W-1:0] sd_i,
  input  logic [STD_DEV_W-1:0] rem_i,
  input  logic [QW-1:0]        num_i,
  input  logic [QW-1:0]        quo_i,
  output logic                 valid_o,
  output zsle_flags_t          flags_o,
  output logic [STD_DEV_W-1:0] rem_o,
  output logic [QW-1:0]        num_o,
  output logic [QW-1:0]        quo_o
);

  logic [STD_DEV_W:0]   trial;
  logic                 ge;
  logic [STD_DEV_W-1:0] rem_d;

  assign trial = {rem_i, num_i[QW-1]};
  assign ge    = trial >= {1'b0, sd_i};
  // remainder stays below the divisor, so it fits the divisor width
  assign rem_d = ge ? STD_DEV_W'(trial - {1'b0, sd_i}) : trial[STD_DEV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o <= flags_i;
      rem_o   <= rem_d;
      num_o   <= {num_i[QW-2:0], 1'b0};
      quo_o   <= {quo_i[QW-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/z_score_log_evalue.sv -----
`timescale 1ns / 1ps
// Top level: score to log10 E-value pipeline.
// Depends on zsle_pkg, zsle_if and zsle_div_cell.
//
// Usage
//   in_i  : one score per item, signed Q16.16, valid/ready.
//   out_o : one result per item, in order: log_evalue (signed Q8.16,
//           saturated), below_mean, clamped.
//   cfg_i : register writes (0 mean, 1 std dev, 2 log db size); other
//           indexes are ignored. Always ready; write only while idle.
//   Scores below the mean give exactly 1.0 with below_mean set.
//   Otherwise t = 10*(score-mean)/std_dev is found by a row of division
//   cells, one quotient bit per cell, then a tail table is interpolated
//   and the log db size added.
// Throughput: one item per cycle while out_o.ready is held high.
// Stages: A, B, the division cell row (one cell for each quotient bit),
//   L, M and the output register, in that order.
// Reset: all stages empty; mean 0, std dev 1.0, log db size 0.
// Stall: each stage holds while the next is full and stalled; bubbles
//   close up, so items keep entering until every stage is full.
module z_score_log_evalue import zsle_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  zsle_in_if.sink    in_i,
  zsle_out_if.source out_o,
  zsle_cfg_if.sink   cfg_i
);

  localparam int LW   = $clog2(TABLE_ENTRIES);       // index bits
  localparam int QW   = LW + FRAC_BITS;              // quotient bits kept
  localparam int PW   = SCORE_W + 4;                 // diff * 10
  localparam int VW   = FRAC_BITS + 6;               // table value, signed
  localparam int MW   = VW + 2;                      // interpolated value
  localparam int SUMW = ((MW > DB_SIZE_W) ? MW : DB_SIZE_W) + 2;

  // ---- configuration registers ----
  logic signed [SCORE_W-1:0]   mean_q;
  logic        [STD_DEV_W-1:0] sd_q;
  logic signed [DB_SIZE_W-1:0] db_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      sd_q   <= STD_DEV_W'(1) << FRAC_BITS;
      db_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MEAN:    mean_q <= cfg_i.data[SCORE_W-1:0];
        CFG_STD_DEV: sd_q   <= cfg_i.data[STD_DEV_W-1:0];
        CFG_DB_SIZE: db_q   <= cfg_i.data[DB_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- tail table, built at elaboration ----
  logic signed [VW-1:0] tbl [TABLE_ENTRIES];
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_tbl
    assign tbl[g] = VW'(tail_val(g, FRAC_BITS));
  end

  // ---- stage ready chain ----
  logic a_valid_q, b_valid_q, l_valid_q, m_valid_q, out_valid_q;
  logic rdy_a, rdy_b, rdy_l, rdy_m, rdy_out;
  logic [QW-1:0] rdy_c;
  logic          c_valid [QW];

  assign rdy_out = !out_valid_q || out_o.ready;
  assign rdy_m   = !m_valid_q || rdy_out;
  assign rdy_l   = !l_valid_q || rdy_m;
  for (genvar k = 0; k < QW; k++) begin : g_rdy
    if (k == QW - 1) begin : g_last
      assign rdy_c[k] = !c_valid[k] || rdy_l;
    end else begin : g_mid
      assign rdy_c[k] = !c_valid[k] || rdy_c[k+1];
    end
  end
  assign rdy_b   = !b_valid_q || rdy_c[0];
  assign rdy_a   = !a_valid_q || rdy_b;
  assign in_i.ready = rdy_a;

  // ---- stage A: score minus mean ----
  logic signed [SCORE_W:0] a_diff_d;
  logic        [SCORE_W-1:0] a_diff_q;
  logic                      a_below_q;

  assign a_diff_d = {in_i.score_value[SCORE_W-1], in_i.score_value}
                  - {mean_q[SCORE_W-1], mean_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (rdy_a) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_diff_q  <= a_diff_d[SCORE_W-1:0];
      a_below_q <= a_diff_d[SCORE_W];
    end
  end

  // ---- stage B: times ten, split numerator, overflow check ----
  logic [PW-1:0]        b_prod;
  logic [PW-1:0]        b_hi;
  logic                 b_ovf;
  zsle_flags_t          b_flags_q;
  logic [STD_DEV_W-1:0] b_rem_q;
  logic [QW-1:0]        b_num_q;

  assign b_prod = (PW'(a_diff_q) << 3) + (PW'(a_diff_q) << 1);
  assign b_hi   = b_prod >> LW;
  // quotient would not fit QW bits: index is past the table anyway
  assign b_ovf  = (b_hi >= PW'(sd_q)) || (sd_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (rdy_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      b_flags_q.below <= a_below_q;
      b_flags_q.clamp <= b_ovf;
      b_rem_q         <= b_hi[STD_DEV_W-1:0];
      b_num_q         <= {b_prod[LW-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // ---- division cell row ----
  zsle_flags_t          c_flags [QW];
  logic [STD_DEV_W-1:0] c_rem   [QW];
  logic [QW-1:0]        c_num   [QW];
  logic [QW-1:0]        c_quo   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_cell
    if (k == 0) begin : g_first
      zsle_div_cell #(.QW(QW)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (rdy_c[k]),
        .valid_i (b_valid_q),
        .flags_i (b_flags_q),
        .sd_i    (sd_q),
        .rem_i   (b_rem_q),
        .num_i   (b_num_q),
        .quo_i   ('0),
        .valid_o (c_valid[k]),
        .flags_o (c_flags[k]),
        .rem_o   (c_rem[k]),
        .num_o   (c_num[k]),
        .quo_o   (c_quo[k])
      );
    end else begin : g_next
      zsle_div_cell #(.QW(QW)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (rdy_c[k]),
        .valid_i (c_valid[k-1]),
        .flags_i (c_flags[k-1]),
        .sd_i    (sd_q),
        .rem_i   (c_rem[k-1]),
        .num_i   (c_num[k-1]),
        .quo_i   (c_quo[k-1]),
        .valid_o (c_valid[k]),
        .flags_o (c_flags[k]),
        .rem_o   (c_rem[k]),
        .num_o   (c_num[k]),
        .quo_o   (c_quo[k])
      );
    end
  end

  // ---- stage L: table lookup ----
  logic [LW-1:0]         l_lo;
  logic                  l_clamp;
  logic [LW-1:0]         l_idx;
  logic [LW-1:0]         l_idx1;
  logic signed [VW-1:0]  l_vlo_q;
  logic signed [VW:0]    l_d_q;
  logic [FRAC_BITS-1:0]  l_frac_q;
  zsle_flags_t           l_flags_q;

  assign l_lo    = c_quo[QW-1][QW-1:FRAC_BITS];
  assign l_clamp = c_flags[QW-1].clamp
                || ({1'b0, l_lo} >= (LW+1)'(TABLE_ENTRIES - 1));
  assign l_idx   = l_clamp ? LW'(TABLE_ENTRIES - 1) : l_lo;
  assign l_idx1  = l_clamp ? l_idx : LW'(l_lo + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (rdy_l) begin
      l_valid_q <= c_valid[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_l) begin
      l_vlo_q         <= tbl[l_idx];
      l_d_q           <= {tbl[l_idx1][VW-1], tbl[l_idx1]} - {tbl[l_idx][VW-1], tbl[l_idx]};
      l_frac_q        <= l_clamp ? '0 : c_quo[QW-1][FRAC_BITS-1:0];
      l_flags_q.below <= c_flags[QW-1].below;
      l_flags_q.clamp <= l_clamp;
    end
  end

  // ---- stage M: interpolation, term truncated toward zero ----
  logic                      m_neg;
  logic [VW:0]               m_mag;
  logic [VW+1+FRAC_BITS-1:0] m_prod;
  logic signed [MW-1:0]      m_term;
  logic signed [MW-1:0]      m_val_d;
  logic signed [MW-1:0]      m_val_q;
  zsle_flags_t               m_flags_q;

  assign m_neg   = l_d_q[VW];
  assign m_mag   = m_neg ? (VW+1)'(-l_d_q) : l_d_q;
  assign m_prod  = (VW+1+FRAC_BITS)'(m_mag) * (VW+1+FRAC_BITS)'(l_frac_q);
  assign m_term  = MW'(m_prod >> FRAC_BITS);
  assign m_val_d = m_neg ? MW'(l_vlo_q) - m_term : MW'(l_vlo_q) + m_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (rdy_m) begin
      m_valid_q <= l_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m) begin
      m_val_q   <= m_val_d;
      m_flags_q <= l_flags_q;
    end
  end

  // ---- output stage: add db size, pick 1.0 when below mean, saturate ----
  localparam logic signed [SUMW-1:0] ONE_FX  = SUMW'(1) << FRAC_BITS;
  localparam logic signed [SUMW-1:0] OUT_MAX = SUMW'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [SUMW-1:0] OUT_MIN = -(SUMW'(1) << (OUT_W - 1));

  logic signed [SUMW-1:0]  o_sum;
  logic signed [SUMW-1:0]  o_pick;
  logic signed [OUT_W-1:0] o_sat;
  logic signed [OUT_W-1:0] out_val_q;
  zsle_flags_t             out_flags_q;

  assign o_sum  = SUMW'(m_val_q) + SUMW'(db_q);
  assign o_pick = m_flags_q.below ? ONE_FX : o_sum;
  assign o_sat  = (o_pick > OUT_MAX) ? OUT_MAX[OUT_W-1:0]
                : (o_pick < OUT_MIN) ? OUT_MIN[OUT_W-1:0]
                : o_pick[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_val_q         <= o_sat;
      out_flags_q.below <= m_flags_q.below;
      out_flags_q.clamp <= m_flags_q.clamp && !m_flags_q.below;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.log_evalue = out_val_q;
  assign out_o.below_mean = out_flags_q.below;
  assign out_o.clamped    = out_flags_q.clamp;

endmodule
